### hw/rtl/assert_macros.svh
// Assertion helpers, clocked on the block clock and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHECK_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define CHECK_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### hw/rtl/mrpt_pkg.sv
package mrpt_pkg;

   localparam logic [63:0] SMALL_LIMIT       = 64'd1000000;
   localparam logic [10:0] FIRST_ODD_DIVISOR = 11'd201;
   localparam logic [20:0] FIRST_ODD_SQUARE  = 21'd40401;
   localparam int          NUM_SMALL_PRIMES  = 46;
   localparam int          KW                = $clog2(NUM_SMALL_PRIMES);

   typedef logic [1:0] verdict_type;
   localparam verdict_type VERDICT_COMPOSITE = 2'd0;
   localparam verdict_type VERDICT_PRIME     = 2'd1;
   localparam verdict_type VERDICT_UNDEFINED = 2'd2;

   typedef logic [7:0] prime_type [NUM_SMALL_PRIMES];
   localparam prime_type SMALL_PRIMES = '{
      8'd2,   8'd3,   8'd5,   8'd7,   8'd11,  8'd13,  8'd17,  8'd19,  8'd23,  8'd29,
      8'd31,  8'd37,  8'd41,  8'd43,  8'd47,  8'd53,  8'd59,  8'd61,  8'd67,  8'd71,
      8'd73,  8'd79,  8'd83,  8'd89,  8'd97,  8'd101, 8'd103, 8'd107, 8'd109, 8'd113,
      8'd127, 8'd131, 8'd137, 8'd139, 8'd149, 8'd151, 8'd157, 8'd163, 8'd167, 8'd173,
      8'd179, 8'd181, 8'd191, 8'd193, 8'd197, 8'd199
   };

endpackage

### hw/rtl/miller_rabin_primality_test_top.sv
// channel | direction | ports
// req     | in        | req_valid, req_stall, req_candidate, req_witness, req_last_witness
// rsp     | out       | rsp_valid, rsp_stall, rsp_verdict
//
// One modular multiply (shift-add, full reduction) works on W = min(NUMBER_WIDTH, 63) bits.
// Large candidate: up to ~125 multiplies per item at W = 63.
// Small final candidate: up to ~450 remainders; below 4 it needs none, and a non-final one gives no verdict.
// req_stall is high from the accepting edge until the sequencer is idle again.
// Synchronous reset clears the sequencer, rsp_valid and the composite flag.
// A held result blocks only the next verdict; the sequencer waits in its emit state.
module miller_rabin_primality_test_top
   import mrpt_pkg::*;
#(
   parameter int NUMBER_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [62:0] req_candidate,
   input  logic [62:0] req_witness,
   input  logic        req_last_witness,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_verdict
);
   `include "assert_macros.svh"

   localparam int VW = (NUMBER_WIDTH > 63) ? 63 : NUMBER_WIDTH;
   localparam int CW = $clog2(VW);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_RED, S_TP, S_OD_TEST, S_OD_CHK, S_SHIFT,
      S_PW_TEST, S_PW_MULR, S_PW_SQB, S_CHK, S_SQ_TEST, S_SQ_CHK, S_FIN, S_EMIT
   } state_type;

   state_type   state_ff, ret_ff;
   logic [VW-1:0] x_ff, w_ff;
   logic        last_ff;
   logic        comp_seen_ff, comp_ff;
   verdict_type pend_ff, verdict_ff;
   logic        rsp_valid_ff;
   // shared multiply unit
   logic [VW-1:0] ma_ff, mb_ff, mm_ff, mr_ff;
   logic [CW-1:0] cnt_ff;
   logic        ph_ff;
   // sequencer data
   logic [KW-1:0] k_ff;
   logic [10:0] d_ff;
   logic [20:0] sq_ff;
   logic [VW-1:0] e_ff, base_ff, pr_ff;
   logic [CW-1:0] s_ff, j_ff;

   logic [VW:0]   dbl, add_sum, mmx, step_sum;
   logic [VW-1:0] step_r, xm1;
   logic          x_large, x_small2, x_small4;

   always_comb begin
      mmx      = {1'b0, mm_ff};
      dbl      = {mr_ff, 1'b0};
      add_sum  = {1'b0, mr_ff} + {1'b0, ma_ff};
      step_sum = ph_ff ? add_sum : dbl;
      step_r   = (step_sum >= mmx) ? VW'(step_sum - mmx) : step_sum[VW-1:0];
      xm1      = x_ff - VW'(1);
      x_large  = 64'(x_ff) >= SMALL_LIMIT;
      x_small2 = 64'(x_ff) < 64'd2;
      x_small4 = 64'(x_ff) < 64'd4;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = verdict_ff;

   always_ff @(posedge clock) begin
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_ff     <= req_candidate[VW-1:0];
               w_ff     <= req_witness[VW-1:0];
               last_ff  <= req_last_witness;
               k_ff     <= '0;
               d_ff     <= FIRST_ODD_DIVISOR;
               sq_ff    <= FIRST_ODD_SQUARE;
               comp_ff  <= 1'b0;
               state_ff <= S_FIN;
            end
         end
         S_FIN: begin
            // first pass after accept: choose path; later passes close a round
            if (ret_ff != S_FIN) begin
               ret_ff <= S_FIN;
               if (x_large) begin
                  if (!x_ff[0]) begin
                     comp_ff <= 1'b1;
                  end else begin
                     ma_ff    <= VW'(1);
                     mb_ff    <= w_ff;
                     mm_ff    <= x_ff;
                     mr_ff    <= '0;
                     cnt_ff   <= CW'(VW - 1);
                     ph_ff    <= 1'b0;
                     ret_ff   <= S_RED;
                     state_ff <= S_MUL;
                  end
               end else if (!last_ff) begin
                  ret_ff   <= S_IDLE;
                  state_ff <= S_IDLE;
               end else if (x_small2) begin
                  pend_ff  <= VERDICT_UNDEFINED;
                  state_ff <= S_EMIT;
               end else if (x_small4) begin
                  pend_ff  <= VERDICT_PRIME;
                  state_ff <= S_EMIT;
               end else begin
                  ma_ff    <= VW'(1);
                  mb_ff    <= x_ff;
                  mm_ff    <= VW'(SMALL_PRIMES[0]);
                  mr_ff    <= '0;
                  cnt_ff   <= CW'(VW - 1);
                  ph_ff    <= 1'b0;
                  ret_ff   <= S_TP;
                  state_ff <= S_MUL;
               end
            end else begin
               ret_ff <= S_IDLE;
               if (last_ff) begin
                  pend_ff      <= (comp_seen_ff || comp_ff) ? VERDICT_COMPOSITE
                                                            : VERDICT_PRIME;
                  comp_seen_ff <= 1'b0;
                  state_ff     <= S_EMIT;
               end else begin
                  comp_seen_ff <= comp_seen_ff | comp_ff;
                  state_ff     <= S_IDLE;
               end
            end
         end
         S_MUL: begin
            mr_ff <= step_r;
            if (!ph_ff) begin
               ph_ff <= 1'b1;
            end else begin
               ph_ff <= 1'b0;
               if (!mb_ff[cnt_ff]) begin
                  mr_ff <= mr_ff;
               end
               if (cnt_ff == '0) begin
                  state_ff <= ret_ff;
               end else begin
                  cnt_ff <= cnt_ff - CW'(1);
               end
            end
         end
         S_TP: begin
            if (mr_ff == '0) begin
               pend_ff  <= (x_ff == VW'(SMALL_PRIMES[k_ff])) ? VERDICT_PRIME
                                                               : VERDICT_COMPOSITE;
               state_ff <= S_EMIT;
            end else if (k_ff == KW'(NUM_SMALL_PRIMES - 1)) begin
               state_ff <= S_OD_TEST;
            end else begin
               k_ff     <= k_ff + KW'(1);
               mm_ff    <= VW'(SMALL_PRIMES[k_ff + KW'(1)]);
               mr_ff    <= '0;
               cnt_ff   <= CW'(VW - 1);
               state_ff <= S_MUL;
            end
         end
         S_OD_TEST: begin
            if (64'(sq_ff) > 64'(x_ff)) begin
               pend_ff  <= VERDICT_PRIME;
               state_ff <= S_EMIT;
            end else begin
               mm_ff    <= VW'(d_ff);
               mr_ff    <= '0;
               cnt_ff   <= CW'(VW - 1);
               ret_ff   <= S_OD_CHK;
               state_ff <= S_MUL;
            end
         end
         S_OD_CHK: begin
            if (mr_ff == '0) begin
               pend_ff  <= VERDICT_COMPOSITE;
               state_ff <= S_EMIT;
            end else begin
               sq_ff    <= sq_ff + {8'd0, d_ff, 2'b00} + 21'd4;
               d_ff     <= d_ff + 11'd2;
               state_ff <= S_OD_TEST;
            end
         end
         S_RED: begin
            ret_ff <= S_FIN;
            if (mr_ff == '0 || mr_ff == VW'(1) || mr_ff == xm1) begin
               state_ff <= S_FIN;
            end else begin
               base_ff  <= mr_ff;
               e_ff     <= xm1;
               s_ff     <= '0;
               pr_ff    <= VW'(1);
               state_ff <= S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (!e_ff[0]) begin
               e_ff <= e_ff >> 1;
               s_ff <= s_ff + CW'(1);
            end else begin
               state_ff <= S_PW_TEST;
            end
         end
         S_PW_TEST: begin
            mm_ff  <= x_ff;
            mr_ff  <= '0;
            cnt_ff <= CW'(VW - 1);
            ph_ff  <= 1'b0;
            state_ff <= S_MUL;
            if (e_ff == '0) begin
               state_ff <= S_CHK;
            end else if (e_ff[0]) begin
               ma_ff  <= pr_ff;
               mb_ff  <= base_ff;
               ret_ff <= S_PW_MULR;
            end else begin
               ma_ff  <= base_ff;
               mb_ff  <= base_ff;
               ret_ff <= S_PW_SQB;
            end
         end
         S_PW_MULR: begin
            pr_ff    <= mr_ff;
            ma_ff    <= base_ff;
            mb_ff    <= base_ff;
            mr_ff    <= '0;
            cnt_ff   <= CW'(VW - 1);
            ret_ff   <= S_PW_SQB;
            state_ff <= S_MUL;
         end
         S_PW_SQB: begin
            base_ff  <= mr_ff;
            e_ff     <= e_ff >> 1;
            state_ff <= S_PW_TEST;
         end
         S_CHK: begin
            ret_ff <= S_FIN;
            j_ff   <= CW'(1);
            if (pr_ff == VW'(1) || pr_ff == xm1) begin
               state_ff <= S_FIN;
            end else begin
               state_ff <= S_SQ_TEST;
            end
         end
         S_SQ_TEST: begin
            if (j_ff >= s_ff) begin
               comp_ff  <= 1'b1;
               ret_ff   <= S_FIN;
               state_ff <= S_FIN;
            end else begin
               ma_ff    <= pr_ff;
               mb_ff    <= pr_ff;
               mr_ff    <= '0;
               cnt_ff   <= CW'(VW - 1);
               ret_ff   <= S_SQ_CHK;
               state_ff <= S_MUL;
            end
         end
         S_SQ_CHK: begin
            pr_ff <= mr_ff;
            j_ff  <= j_ff + CW'(1);
            if (mr_ff == xm1) begin
               ret_ff   <= S_FIN;
               state_ff <= S_FIN;
            end else begin
               state_ff <= S_SQ_TEST;
            end
         end
         S_EMIT: begin
            ret_ff <= S_IDLE;
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_ff <= 1'b1;
               verdict_ff   <= pend_ff;
               comp_seen_ff <= 1'b0;
               state_ff     <= S_IDLE;
            end
         end
         default: begin
            state_ff <= S_IDLE;
         end
      endcase
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         comp_seen_ff <= 1'b0;
         ph_ff        <= 1'b0;
      end
   end

   `CHECK_IMPLIES(a_mod_nonzero, clock, reset, state_ff == S_MUL, mm_ff != '0, "modulus zero")
   `CHECK_IMPLIES(a_rem_reduced, clock, reset, state_ff == S_MUL, mr_ff < mm_ff, "remainder not reduced")
   `CHECK_IMPLIES(a_verdict_code, clock, reset, rsp_valid, rsp_verdict != 2'd3, "bad verdict code")

endmodule
